// ===== rtl/core/bmm_pkg.sv =====
package bmm_pkg;

  localparam int MaxLeft = 32;
  localparam int MaxRight = 32;
  localparam int MaxEdges = 256;
  localparam int LW = 5;
  localparam int RW = 5;
  localparam int EW = 8;
  localparam int ECW = 9;
  localparam int CW = 6;
  localparam int SPW = 6;

  localparam logic CfgNumLeft = 1'b0;
  localparam logic CfgNumRight = 1'b1;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_BFS_SEED,
    ST_BFS_POP,
    ST_BFS_SCAN,
    ST_BFS_WAIT,
    ST_BFS_CHK,
    ST_DFS_ROOT,
    ST_DFS_TOP,
    ST_DFS_SCAN,
    ST_DFS_WAIT,
    ST_DFS_CHK,
    ST_AUG_RD,
    ST_AUG_WAIT,
    ST_AUG_WR,
    ST_PHASE_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic           wr;
    logic [EW-1:0]  addr;
    logic [LW-1:0]  left;
    logic [RW-1:0]  right;
  } edge_wr_t;

  // Clamp a 6-bit register to 1..32.
  function automatic logic [CW-1:0] clamp_cnt(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) r = CW'(1);
    else if (v > CW'(32)) r = CW'(32);
    return r;
  endfunction

endpackage

// ===== rtl/core/bmm_edge_mem.sv =====
module bmm_edge_mem (
  input  logic                        clk,
  input  bmm_pkg::edge_wr_t           wr,
  input  logic [bmm_pkg::EW-1:0]      rd_addr,
  output logic [bmm_pkg::LW-1:0]      rd_left,
  output logic [bmm_pkg::RW-1:0]      rd_right
);

  logic [bmm_pkg::LW+bmm_pkg::RW-1:0] mem [bmm_pkg::MaxEdges];
  logic [bmm_pkg::LW+bmm_pkg::RW-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr.wr) begin
      mem[wr.addr] <= {wr.left, wr.right};
    end
    q_r <= mem[rd_addr];
  end

  assign rd_left = q_r[bmm_pkg::LW+bmm_pkg::RW-1:bmm_pkg::RW];
  assign rd_right = q_r[bmm_pkg::RW-1:0];

endmodule

// ===== rtl/core/bipartite_max_matching.sv =====
// Maximum bipartite matching (Hopcroft-Karp). Edges load at one transaction per
// cycle, while in_ready is high, into a 256-entry edge memory with one read
// port. On the transaction marked last_edge the block clears the matching and
// runs phases of BFS layering and explicit-stack layered DFS. Every neighbor
// lookup is a linear scan of the edge memory that, for each stored edge, issues
// the address, waits out the read latency and checks the entry. Compute time
// grows with phases x visited vertices x stored edges, plus seeding of num_left
// vertices per phase, and is set by that single read port. Results then stream
// out, one per right vertex; input is held off until the last result is taken.
module bipartite_max_matching (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_left_vertex,
  input  logic [4:0] in_right_vertex,
  input  logic       in_edge_valid,
  input  logic       in_last_edge,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_right_index,
  output logic       out_is_matched,
  output logic [4:0] out_partner_left,
  output logic [5:0] out_matching_size,
  output logic       out_edge_overflow,
  output logic       out_last_result
);

  localparam int LW = bmm_pkg::LW;
  localparam int EW = bmm_pkg::EW;
  localparam int ECW = bmm_pkg::ECW;
  localparam int CW = bmm_pkg::CW;
  localparam int SPW = bmm_pkg::SPW;

  bmm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  num_left_r, num_right_r;
  logic [ECW-1:0] edge_total_r, edge_total_nxt;
  logic           ovf_r, ovf_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  flow_r, flow_nxt;

  // Small per-vertex state; partner kept as valid bit plus left index.
  logic [31:0]    rp_v_r, rp_v_nxt;
  logic [LW-1:0]  rp_l_r [32];
  logic [31:0]    lm_r, lm_nxt;
  logic [31:0]    vis_r, vis_nxt;
  logic [31:0]    lay_v_r, lay_v_nxt;
  logic [CW-1:0]  lay_r [32];

  // Layers strictly increase along the DFS path, so it never holds more
  // than one frame per left vertex.
  logic [LW-1:0]  q_r [32];
  logic [CW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [LW-1:0]  stk_v_r [32];
  logic [ECW-1:0] stk_e_r [32];
  logic [SPW-1:0] sp_r, sp_nxt;

  logic [CW-1:0]  idx_r, idx_nxt;     // vertex loop index
  logic [LW-1:0]  cur_r, cur_nxt;     // vertex being scanned
  logic [ECW-1:0] k_r, k_nxt;         // scan position
  logic [4:0]     emit_r, emit_nxt;

  // Write requests for array state.
  logic           rp_we;  logic [4:0] rp_wa; logic [LW-1:0] rp_wd;
  logic           lay_we; logic [LW-1:0] lay_wa; logic [CW-1:0] lay_wd;
  logic           q_we;   logic [LW-1:0] q_wa;  logic [LW-1:0] q_wd;
  logic           sv_we;  logic [LW-1:0] sv_wa; logic [LW-1:0] sv_wd;
  logic           se_we;  logic [LW-1:0] se_wa; logic [ECW-1:0] se_wd;

  logic [CW-1:0]  n, m;
  bmm_pkg::edge_wr_t ewr;
  logic [EW-1:0]  rd_addr;
  logic [LW-1:0]  rd_left;
  logic [4:0]     rd_right;
  logic           in_acc, take;

  assign n = bmm_pkg::clamp_cnt(num_left_r);
  assign m = bmm_pkg::clamp_cnt(num_right_r);
  assign in_ready = (state_r == bmm_pkg::ST_LOAD);
  assign in_acc = in_valid && in_ready;
  assign take = in_acc && in_edge_valid && ({1'b0, in_left_vertex} < n)
                && ({1'b0, in_right_vertex} < m);

  always_comb begin
    ewr.wr = take && (edge_total_r < ECW'(bmm_pkg::MaxEdges));
    ewr.addr = edge_total_r[EW-1:0];
    ewr.left = in_left_vertex;
    ewr.right = in_right_vertex;
  end

  assign rd_addr = k_r[EW-1:0];

  bmm_edge_mem u_mem (
    .clk      (clk),
    .wr       (ewr),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  logic [SPW-1:0] top;
  logic [LW-1:0]  top_v;
  logic [LW-1:0]  pu;
  logic           edge_ok;
  assign top = sp_r - SPW'(1);
  assign top_v = stk_v_r[top[LW-1:0]];
  assign pu = rp_l_r[rd_right];
  assign edge_ok = (rd_left == cur_r) && ({1'b0, rd_right} < m);

  always_comb begin
    state_nxt = state_r;
    edge_total_nxt = edge_total_r;
    ovf_nxt = ovf_r;
    count_nxt = count_r;
    flow_nxt = flow_r;
    rp_v_nxt = rp_v_r;
    lm_nxt = lm_r;
    vis_nxt = vis_r;
    lay_v_nxt = lay_v_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    sp_nxt = sp_r;
    idx_nxt = idx_r;
    cur_nxt = cur_r;
    k_nxt = k_r;
    emit_nxt = emit_r;
    rp_we = 1'b0; rp_wa = '0; rp_wd = '0;
    lay_we = 1'b0; lay_wa = '0; lay_wd = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0;
    sv_we = 1'b0; sv_wa = '0; sv_wd = '0;
    se_we = 1'b0; se_wa = '0; se_wd = '0;
    case (state_r)
      bmm_pkg::ST_LOAD: begin
        if (take) begin
          if (edge_total_r < ECW'(bmm_pkg::MaxEdges)) begin
            edge_total_nxt = edge_total_r + ECW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (in_acc && in_last_edge) state_nxt = bmm_pkg::ST_INIT;
      end
      bmm_pkg::ST_INIT: begin
        rp_v_nxt = '0;
        lm_nxt = '0;
        count_nxt = '0;
        state_nxt = bmm_pkg::ST_BFS_SEED;
        idx_nxt = '0;
        tail_nxt = '0;
        head_nxt = '0;
        lay_v_nxt = '0;
      end
      // One vertex per cycle: free left vertices enter the queue at layer 0.
      bmm_pkg::ST_BFS_SEED: begin
        if (idx_r < n) begin
          if (!lm_r[idx_r[LW-1:0]]) begin
            q_we = 1'b1; q_wa = tail_r[LW-1:0]; q_wd = idx_r[LW-1:0];
            tail_nxt = tail_r + CW'(1);
            lay_v_nxt[idx_r[LW-1:0]] = 1'b1;
            lay_we = 1'b1; lay_wa = idx_r[LW-1:0]; lay_wd = '0;
          end
          idx_nxt = idx_r + CW'(1);
        end else begin
          state_nxt = bmm_pkg::ST_BFS_POP;
        end
      end
      bmm_pkg::ST_BFS_POP: begin
        if (head_r < tail_r) begin
          cur_nxt = q_r[head_r[LW-1:0]];
          head_nxt = head_r + CW'(1);
          k_nxt = '0;
          state_nxt = bmm_pkg::ST_BFS_SCAN;
        end else begin
          vis_nxt = '0;
          flow_nxt = '0;
          idx_nxt = '0;
          state_nxt = bmm_pkg::ST_DFS_ROOT;
        end
      end
      bmm_pkg::ST_BFS_SCAN: begin
        if (k_r < edge_total_r) state_nxt = bmm_pkg::ST_BFS_WAIT;
        else state_nxt = bmm_pkg::ST_BFS_POP;
      end
      bmm_pkg::ST_BFS_WAIT: state_nxt = bmm_pkg::ST_BFS_CHK;
      bmm_pkg::ST_BFS_CHK: begin
        if (edge_ok && rp_v_r[rd_right] && ({1'b0, pu} < n) && !lay_v_r[pu]
            && tail_r < CW'(bmm_pkg::MaxLeft)) begin
          q_we = 1'b1; q_wa = tail_r[LW-1:0]; q_wd = pu;
          tail_nxt = tail_r + CW'(1);
          lay_v_nxt[pu] = 1'b1;
          lay_we = 1'b1; lay_wa = pu; lay_wd = lay_r[cur_r] + CW'(1);
        end
        k_nxt = k_r + ECW'(1);
        state_nxt = bmm_pkg::ST_BFS_SCAN;
      end
      bmm_pkg::ST_DFS_ROOT: begin
        if (idx_r < n) begin
          if (!lm_r[idx_r[LW-1:0]]) begin
            sv_we = 1'b1; sv_wa = '0; sv_wd = idx_r[LW-1:0];
            se_we = 1'b1; se_wa = '0; se_wd = '0;
            sp_nxt = SPW'(1);
            vis_nxt[idx_r[LW-1:0]] = 1'b1;
            state_nxt = bmm_pkg::ST_DFS_TOP;
          end
          idx_nxt = idx_r + CW'(1);
        end else begin
          state_nxt = bmm_pkg::ST_PHASE_END;
        end
      end
      bmm_pkg::ST_DFS_TOP: begin
        if (sp_r == '0) begin
          state_nxt = bmm_pkg::ST_DFS_ROOT;
        end else begin
          cur_nxt = top_v;
          k_nxt = stk_e_r[top[LW-1:0]];
          state_nxt = bmm_pkg::ST_DFS_SCAN;
        end
      end
      bmm_pkg::ST_DFS_SCAN: begin
        if (k_r < edge_total_r) begin
          state_nxt = bmm_pkg::ST_DFS_WAIT;
        end else begin
          // Neighbors exhausted: pop and advance the parent's edge.
          sp_nxt = top;
          if (top != '0) begin
            se_we = 1'b1; se_wa = top[LW-1:0] - LW'(1);
            se_wd = stk_e_r[top[LW-1:0] - LW'(1)] + ECW'(1);
          end
          state_nxt = bmm_pkg::ST_DFS_TOP;
        end
      end
      bmm_pkg::ST_DFS_WAIT: state_nxt = bmm_pkg::ST_DFS_CHK;
      bmm_pkg::ST_DFS_CHK: begin
        if (!edge_ok) begin
          k_nxt = k_r + ECW'(1);
          state_nxt = bmm_pkg::ST_DFS_SCAN;
        end else begin
          se_we = 1'b1; se_wa = top[LW-1:0]; se_wd = k_r;
          if (!rp_v_r[rd_right]) begin
            flow_nxt = flow_r + CW'(1);
            state_nxt = bmm_pkg::ST_AUG_RD;
          end else if (({1'b0, pu} < n) && !vis_r[pu] && lay_v_r[pu]
                       && lay_v_r[top_v] && (lay_r[pu] == lay_r[top_v] + CW'(1))
                       && sp_r < SPW'(bmm_pkg::MaxLeft)) begin
            vis_nxt[pu] = 1'b1;
            sv_we = 1'b1; sv_wa = sp_r[LW-1:0]; sv_wd = pu;
            // Parent's frame edge is written through se above; the new
            // frame's edge is cleared to zero by push_frame in the same cycle.
            sp_nxt = sp_r + SPW'(1);
            state_nxt = bmm_pkg::ST_DFS_TOP;
          end else begin
            se_wd = k_r + ECW'(1);
            k_nxt = k_r + ECW'(1);
            state_nxt = bmm_pkg::ST_DFS_SCAN;
          end
        end
      end
      bmm_pkg::ST_AUG_RD: begin
        if (sp_r == '0) begin
          state_nxt = bmm_pkg::ST_DFS_ROOT;
        end else begin
          k_nxt = stk_e_r[top[LW-1:0]];
          state_nxt = bmm_pkg::ST_AUG_WAIT;
        end
      end
      bmm_pkg::ST_AUG_WAIT: state_nxt = bmm_pkg::ST_AUG_WR;
      bmm_pkg::ST_AUG_WR: begin
        rp_v_nxt[rd_right] = 1'b1;
        rp_we = 1'b1; rp_wa = rd_right; rp_wd = top_v;
        lm_nxt[top_v] = 1'b1;
        sp_nxt = top;
        state_nxt = bmm_pkg::ST_AUG_RD;
      end
      bmm_pkg::ST_PHASE_END: begin
        if (flow_r == '0) begin
          emit_nxt = '0;
          state_nxt = bmm_pkg::ST_EMIT;
        end else begin
          count_nxt = count_r + flow_r;
          idx_nxt = '0;
          tail_nxt = '0;
          head_nxt = '0;
          lay_v_nxt = '0;
          state_nxt = bmm_pkg::ST_BFS_SEED;
        end
      end
      bmm_pkg::ST_EMIT: begin
        if (out_ready) begin
          if ({1'b0, emit_r} + CW'(1) == m) begin
            edge_total_nxt = '0;
            ovf_nxt = 1'b0;
            state_nxt = bmm_pkg::ST_LOAD;
          end else begin
            emit_nxt = emit_r + 5'd1;
          end
        end
      end
      default: state_nxt = bmm_pkg::ST_LOAD;
    endcase
  end

  // A pushed frame starts its scan at edge zero.
  logic push_frame;
  assign push_frame = (state_r == bmm_pkg::ST_DFS_CHK) && sv_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmm_pkg::ST_LOAD;
      num_left_r <= CW'(32);
      num_right_r <= CW'(32);
      edge_total_r <= '0;
      ovf_r <= 1'b0;
      count_r <= '0;
      flow_r <= '0;
      rp_v_r <= '0;
      lm_r <= '0;
      vis_r <= '0;
      lay_v_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      sp_r <= '0;
      idx_r <= '0;
      cur_r <= '0;
      k_r <= '0;
      emit_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bmm_pkg::CfgNumLeft) num_left_r <= cfg_data;
        else num_right_r <= cfg_data;
      end
      state_r <= state_nxt;
      edge_total_r <= edge_total_nxt;
      ovf_r <= ovf_nxt;
      count_r <= count_nxt;
      flow_r <= flow_nxt;
      rp_v_r <= rp_v_nxt;
      lm_r <= lm_nxt;
      vis_r <= vis_nxt;
      lay_v_r <= lay_v_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      sp_r <= sp_nxt;
      idx_r <= idx_nxt;
      cur_r <= cur_nxt;
      k_r <= k_nxt;
      emit_r <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rp_we) rp_l_r[rp_wa] <= rp_wd;
    if (lay_we) lay_r[lay_wa] <= lay_wd;
    if (q_we) q_r[q_wa] <= q_wd;
    if (sv_we) stk_v_r[sv_wa] <= sv_wd;
    if (push_frame) stk_e_r[sp_r[LW-1:0]] <= '0;
    if (se_we) stk_e_r[se_wa] <= se_wd;
  end

  assign out_valid = (state_r == bmm_pkg::ST_EMIT);
  assign out_right_index = emit_r;
  assign out_is_matched = rp_v_r[emit_r];
  assign out_partner_left = rp_v_r[emit_r] ? rp_l_r[emit_r] : '0;
  assign out_matching_size = count_r;
  assign out_edge_overflow = ovf_r;
  assign out_last_result = ({1'b0, emit_r} + CW'(1) == m);

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(bmm_pkg::MaxLeft))
    else $error("DFS stack pointer beyond capacity");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("BFS queue head passed tail");
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= ECW'(bmm_pkg::MaxEdges))
    else $error("edge count beyond store");
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> state_r == bmm_pkg::ST_LOAD)
    else $error("emission did not return to loading");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(32))
    else $error("matching size too large");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int StallLimit = 1000000;
  localparam int LongHold = 400;

  typedef struct packed {
    logic [4:0] right_index;
    logic       is_matched;
    logic [4:0] partner_left;
    logic [5:0] matching_size;
    logic       edge_overflow;
    logic       last_result;
  } match_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = bmm_pkg::CfgNumLeft;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [4:0] in_left_vertex = '0;
  logic [4:0] in_right_vertex = '0;
  logic in_edge_valid = 1'b0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] out_right_index;
  logic out_is_matched;
  logic [4:0] out_partner_left;
  logic [5:0] out_matching_size;
  logic out_edge_overflow;
  logic out_last_result;

  always #5 clk = ~clk;

  bipartite_max_matching i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_left_vertex   (in_left_vertex),
    .in_right_vertex  (in_right_vertex),
    .in_edge_valid    (in_edge_valid),
    .in_last_edge     (in_last_edge),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_right_index  (out_right_index),
    .out_is_matched   (out_is_matched),
    .out_partner_left (out_partner_left),
    .out_matching_size(out_matching_size),
    .out_edge_overflow(out_edge_overflow),
    .out_last_result  (out_last_result)
  );

  // Shadow state of the matcher.
  logic [5:0] reg_left = 6'd32;
  logic [5:0] reg_right = 6'd32;
  logic [4:0] edge_l [bmm_pkg::MaxEdges];
  logic [4:0] edge_r [bmm_pkg::MaxEdges];
  int edge_cnt = 0;
  bit edges_dropped = 0;
  int partner_of [bmm_pkg::MaxRight];
  bit left_taken [bmm_pkg::MaxLeft];
  bit seen [bmm_pkg::MaxLeft];
  int depth_of [bmm_pkg::MaxLeft];
  int frontier [bmm_pkg::MaxLeft];
  int stk_v [bmm_pkg::MaxLeft+1];
  int stk_e [bmm_pkg::MaxLeft+1];
  int pair_total;

  match_result_t pending_results[$];
  int mismatch_cnt = 0;
  int fail_cnt = 0;
  int graphs_done = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit no_gaps = 0;
  bit hold_rx = 0;
  int idle_cycles = 0;

  function automatic int clamp_reg(logic [5:0] v);
    if (v == 6'd0) return 1;
    if (v > 6'd32) return 32;
    return int'(v);
  endfunction

  function automatic int next_edge(int v, int from, int m);
    for (int k = from; k < edge_cnt; k++)
      if (edge_l[k] == v && edge_r[k] < m) return k;
    return edge_cnt;
  endfunction

  task automatic build_layers(int n, int m);
    int head, tail, v, j;
    head = 0;
    tail = 0;
    for (int i = 0; i < n; i++) begin
      depth_of[i] = -1;
      if (!left_taken[i] && tail < bmm_pkg::MaxLeft) begin
        frontier[tail++] = i;
        depth_of[i] = 0;
      end
    end
    while (head < tail) begin
      v = frontier[head++];
      for (int k = next_edge(v, 0, m); k < edge_cnt; k = next_edge(v, k + 1, m)) begin
        j = partner_of[edge_r[k]];
        if (j >= 0 && j < n && depth_of[j] == -1 && tail < bmm_pkg::MaxLeft) begin
          frontier[tail++] = j;
          depth_of[j] = depth_of[v] + 1;
        end
      end
    end
  endtask

  function automatic bit augment_from(int root, int n, int m);
    int sp, v, k, u;
    sp = 1;
    stk_v[0] = root;
    stk_e[0] = 0;
    seen[root] = 1;
    while (sp > 0) begin
      v = stk_v[sp-1];
      k = next_edge(v, stk_e[sp-1], m);
      if (k >= edge_cnt) begin
        sp--;
        if (sp > 0) stk_e[sp-1]++;
      end else begin
        stk_e[sp-1] = k;
        u = partner_of[edge_r[k]];
        if (u < 0) begin
          // Flip every edge on the current path.
          while (sp > 0) begin
            sp--;
            partner_of[edge_r[stk_e[sp]]] = stk_v[sp];
            left_taken[stk_v[sp]] = 1;
          end
          return 1;
        end
        if (u < n && !seen[u] && depth_of[u] == depth_of[v] + 1
            && sp < bmm_pkg::MaxLeft + 1) begin
          seen[u] = 1;
          stk_v[sp] = u;
          stk_e[sp] = 0;
          sp++;
        end else begin
          stk_e[sp-1] = k + 1;
        end
      end
    end
    return 0;
  endfunction

  task automatic solve_matching(int n, int m);
    int flow;
    match_result_t res;
    for (int i = 0; i < bmm_pkg::MaxRight; i++) partner_of[i] = -1;
    for (int i = 0; i < bmm_pkg::MaxLeft; i++) left_taken[i] = 0;
    pair_total = 0;
    forever begin
      build_layers(n, m);
      for (int i = 0; i < bmm_pkg::MaxLeft; i++) seen[i] = 0;
      flow = 0;
      for (int i = 0; i < n; i++)
        if (!left_taken[i] && augment_from(i, n, m)) flow++;
      if (flow == 0) break;
      pair_total += flow;
    end
    for (int r = 0; r < m; r++) begin
      res.right_index = 5'(r);
      res.is_matched = partner_of[r] >= 0;
      res.partner_left = (partner_of[r] >= 0) ? 5'(partner_of[r]) : 5'd0;
      res.matching_size = 6'(pair_total);
      res.edge_overflow = edges_dropped;
      res.last_result = (r + 1 == m);
      pending_results.insert(pending_results.size(), res);
    end
    edge_cnt = 0;
    edges_dropped = 0;
    graphs_done++;
  endtask

  task automatic send_edge(int lv, int rv, bit ev, bit last);
    int gap, n, m;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_vertex <= 5'(lv);
    in_right_vertex <= 5'(rv);
    in_edge_valid <= ev;
    in_last_edge <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    n = clamp_reg(reg_left);
    m = clamp_reg(reg_right);
    if (ev && lv < n && rv < m) begin
      if (edge_cnt < bmm_pkg::MaxEdges) begin
        edge_l[edge_cnt] = 5'(lv);
        edge_r[edge_cnt] = 5'(rv);
        edge_cnt++;
      end else begin
        edges_dropped = 1;
      end
    end
    if (last) solve_matching(n, m);
  endtask

  // Registers change only once the block has drained all results.
  task automatic write_reg(logic idx, logic [5:0] val);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bmm_pkg::CfgNumLeft) reg_left = val;
    else reg_right = val;
  endtask

  task automatic random_graph(int max_edges);
    int cnt, n, m, lv, rv;
    bit ev;
    cnt = $urandom_range(1, max_edges);
    n = clamp_reg(reg_left);
    m = clamp_reg(reg_right);
    for (int i = 0; i < cnt; i++) begin
      ev = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 9) == 0) begin
        lv = $urandom_range(0, 31);
        rv = $urandom_range(0, 31);
      end else begin
        lv = $urandom_range(0, n - 1);
        rv = $urandom_range(0, m - 1);
      end
      send_edge(lv, rv, ev, i == cnt - 1);
    end
  endtask

  task automatic test_empty_graph();
    send_edge(0, 0, 0, 1);
    send_edge(31, 31, 0, 1);
  endtask

  task automatic test_corner_edges();
    send_edge(0, 0, 1, 0);
    send_edge(31, 31, 1, 0);
    send_edge(31, 0, 1, 0);
    send_edge(0, 31, 1, 1);
    // A chain that needs an augmenting path longer than one edge.
    send_edge(0, 0, 1, 0);
    send_edge(0, 1, 1, 0);
    send_edge(1, 0, 1, 0);
    send_edge(2, 1, 1, 0);
    send_edge(2, 2, 1, 1);
  endtask

  task automatic test_register_clamp();
    write_reg(bmm_pkg::CfgNumLeft, 6'd0);
    write_reg(bmm_pkg::CfgNumRight, 6'd0);
    send_edge(0, 0, 1, 0);
    send_edge(1, 0, 1, 1);
    write_reg(bmm_pkg::CfgNumLeft, 6'd63);
    write_reg(bmm_pkg::CfgNumRight, 6'd33);
    send_edge(31, 31, 1, 1);
    write_reg(bmm_pkg::CfgNumLeft, 6'd32);
    write_reg(bmm_pkg::CfgNumRight, 6'd32);
  endtask

  task automatic test_out_of_range();
    write_reg(bmm_pkg::CfgNumLeft, 6'd4);
    write_reg(bmm_pkg::CfgNumRight, 6'd3);
    send_edge(5, 1, 1, 0);
    send_edge(1, 3, 1, 0);
    send_edge(1, 2, 1, 0);
    send_edge(3, 0, 1, 1);
  endtask

  task automatic test_edge_overflow();
    write_reg(bmm_pkg::CfgNumLeft, 6'd3);
    write_reg(bmm_pkg::CfgNumRight, 6'd5);
    no_gaps = 1;
    for (int i = 0; i < 262; i++)
      send_edge($urandom_range(0, 2), $urandom_range(0, 4), 1, i == 261);
    no_gaps = 0;
  endtask

  task automatic test_output_backpressure();
    hold_rx = 1;
    random_graph(12);
    random_graph(12);
  endtask

  task automatic test_random_graphs();
    while (items_sent < 370) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(bmm_pkg::CfgNumLeft, 6'($urandom_range(0, 63)));
        write_reg(bmm_pkg::CfgNumRight, 6'($urandom_range(0, 63)));
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      random_graph(30);
    end
    no_gaps = 0;
  endtask

  // Result side: random ready gaps, one long hold on request.
  initial begin
    int w;
    match_result_t got, want;
    @(posedge rst_n);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 14);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_rx = 0;
      end else if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      got = {out_right_index, out_is_matched, out_partner_left, out_matching_size,
             out_edge_overflow, out_last_result};
      if (pending_results.size() == 0) begin
        fail_cnt++;
        $display("Unexpected result transaction: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          fail_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_graph();
    test_corner_edges();
    test_register_clamp();
    test_out_of_range();
    test_edge_overflow();
    write_reg(bmm_pkg::CfgNumLeft, 6'd32);
    write_reg(bmm_pkg::CfgNumRight, 6'd32);
    test_output_backpressure();
    test_random_graphs();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) fail_cnt++;
    $display("Covered %0d edge transactions over %0d graphs, %0d results checked,",
             items_sent, graphs_done, results_seen);
    $display("including register clamping, out-of-range edges and edge store overflow.");
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
